// ----- src/bed_pkg.sv -----
`timescale 1ns / 1ps

package bed_pkg;

    // Width of the hex accumulator; code_value carries its low 32 bits
    localparam int ACC_BITS = 32;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_CTRL = 2'd1;
    localparam logic [1:0] PH_OCT  = 2'd2;
    localparam logic [1:0] PH_HEX  = 2'd3;

    localparam logic [1:0] KIND_RAW     = 2'd0;
    localparam logic [1:0] KIND_UCS     = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    localparam logic [3:0] OCT_DIGITS  = 4'd3;
    localparam logic [3:0] HEX_X_LIMIT = 4'd2;
    localparam logic [3:0] HEX_U_LIMIT = 4'd4;
    localparam logic [3:0] HEX_W_LIMIT = 4'd8;
    localparam logic [3:0] COUNT_MAX   = 4'd15;

    typedef struct packed {
        logic [7:0] char_in;
        logic       no_more;
    } t_in;

    typedef struct packed {
        logic [31:0] code_value;
        logic [1:0]  code_kind;
        logic [1:0]  returned_chars;
    } t_out;

    typedef struct packed {
        logic [1:0]          phase;
        logic                is_x;
        logic [3:0]          count;
        logic [3:0]          limit;
        logic [ACC_BITS-1:0] acc;
    } t_state;

    localparam t_state STATE_IDLE = '{
        phase: PH_IDLE, is_x: 1'b0, count: 4'd0, limit: 4'd0, acc: '0
    };

endpackage

// ----- src/backslash_escape_decoder.sv -----
`timescale 1ns / 1ps

// Backslash escape decoder.
// Feed the characters that follow a backslash on the input channel, one per
// transfer; set no_more when the text has ended. At most one result transfer
// leaves for each input transfer, once the escape is complete (a letter, the
// last digit allowed, or the terminator that ends a digit run).
// c_style is written through i_cfg_we / i_cfg_wdata; the user must write it
// only between escapes, as the block itself does not enforce it. An input
// transfer loads the input register; one pass of decode logic then fills
// the result register, from which the result leaves.
// Throughput: one input transfer per cycle, sustained, while results drain.
// The input stalls only while the input register holds an item that completes
// an escape, the result register is full and the receiver stalls.
// Reset clears c_style, the escape state and both valid flags; the block
// accepts input as soon as reset is released.

module backslash_escape_decoder
    import bed_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata
);

    logic   r_c_style;
    logic   r_in_valid;
    t_in    r_in;
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    t_out   r_out;
    t_out   n_out;
    logic   n_has;
    logic   w_out_free;
    logic   w_advance;

    bed_step u_step (
        .i_state      (r_state),
        .i_item       (r_in),
        .i_c_style    (r_c_style),
        .o_state      (n_state),
        .o_result     (n_out),
        .o_has_result (n_has)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && (!n_has || w_out_free);
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_style   <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_IDLE;
        end else begin
            if (i_cfg_we) begin
                r_c_style <= i_cfg_wdata;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_state <= n_state;
            end
            if (w_advance && n_has) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
        if (w_advance && n_has) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && n_has))
        else $error("input stalled without a full, stalled result register");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_IDLE) |-> (r_state.count == 4'd0 && r_state.acc == '0))
        else $error("idle phase left digit state behind");

    a_oct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_OCT) |->
            (r_state.limit == OCT_DIGITS && r_state.count < OCT_DIGITS
             && (r_state.acc >> 9) == '0))
        else $error("octal run beyond its digit limit");

    a_hex_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_HEX && r_state.limit != 4'd0) |->
            (r_state.count < r_state.limit))
        else $error("hex run beyond its digit limit");

endmodule

// ----- src/bed_step.sv -----
`timescale 1ns / 1ps

module bed_step
    import bed_pkg::*;
(
    input  t_state i_state,
    input  t_in    i_item,
    input  logic   i_c_style,
    output t_state o_state,
    output t_out   o_result,
    output logic   o_has_result
);

    logic [7:0]          w_c;
    logic                w_none;
    logic                w_hex_ok;
    logic [3:0]          w_hex_val;
    logic [8:0]          w_oct_acc;
    logic [3:0]          w_oct_cnt;
    logic [ACC_BITS-1:0] w_hex_acc;
    logic [3:0]          w_hex_cnt;
    logic [ACC_BITS-1:0] w_fin_acc;
    logic                w_fin_ucs;

    assign w_c    = i_item.char_in;
    assign w_none = i_item.no_more;

    always_comb begin
        w_hex_ok  = 1'b1;
        w_hex_val = 4'd0;
        case (w_c) inside
            ["0":"9"]: w_hex_val = w_c[3:0];
            ["A":"F"], ["a":"f"]: w_hex_val = w_c[3:0] + 4'd9;
            default: w_hex_ok = 1'b0;
        endcase
        if (w_none) begin
            w_hex_ok = 1'b0;
        end
    end

    assign w_oct_acc = {i_state.acc[5:0], w_c[2:0]};
    assign w_oct_cnt = i_state.count + 4'd1;
    assign w_hex_acc = {i_state.acc[ACC_BITS-5:0], w_hex_val};
    assign w_hex_cnt = (i_state.count < COUNT_MAX) ? i_state.count + 4'd1 : i_state.count;

    // Completed hex value: the digit just taken when the limit is hit, else the run so far
    assign w_fin_acc = w_hex_ok ? w_hex_acc : i_state.acc;
    assign w_fin_ucs = (i_c_style && ((w_fin_acc >> 8) != '0)) || !i_state.is_x;

    always_comb begin
        o_state      = i_state;
        o_result     = '0;
        o_has_result = 1'b0;
        case (i_state.phase)
            PH_CTRL: begin
                o_state      = STATE_IDLE;
                o_has_result = 1'b1;
                o_result.code_kind = KIND_RAW;
                if (!w_none) begin
                    o_result.code_value = (w_c == "?") ? 32'h7F : {24'd0, w_c & 8'h9F};
                end
            end
            PH_OCT: begin
                if (w_none || !(w_c inside {["0":"7"]})) begin
                    o_state      = STATE_IDLE;
                    o_has_result = 1'b1;
                    o_result.code_value     = {24'd0, i_state.acc[7:0]};
                    o_result.returned_chars = 2'd1;
                end else if (w_oct_cnt >= i_state.limit) begin
                    o_state      = STATE_IDLE;
                    o_has_result = 1'b1;
                    o_result.code_value = {24'd0, w_oct_acc[7:0]};
                end else begin
                    o_state.acc   = ACC_BITS'(w_oct_acc);
                    o_state.count = w_oct_cnt;
                end
            end
            PH_HEX: begin
                if (!w_hex_ok) begin
                    o_state      = STATE_IDLE;
                    o_has_result = 1'b1;
                    if (i_state.count == 4'd0) begin
                        o_result.code_kind      = KIND_UNKNOWN;
                        o_result.returned_chars = 2'd2;
                    end else begin
                        o_result.code_value     = 32'(w_fin_acc);
                        o_result.code_kind      = w_fin_ucs ? KIND_UCS : KIND_RAW;
                        o_result.returned_chars = 2'd1;
                    end
                end else if (i_state.limit != 4'd0 && w_hex_cnt >= i_state.limit) begin
                    o_state      = STATE_IDLE;
                    o_has_result = 1'b1;
                    o_result.code_value = 32'(w_fin_acc);
                    o_result.code_kind  = w_fin_ucs ? KIND_UCS : KIND_RAW;
                end else begin
                    o_state.acc   = w_hex_acc;
                    o_state.count = w_hex_cnt;
                end
            end
            default: begin
                // Escape letter
                o_state      = STATE_IDLE;
                o_state.is_x = !w_none && (w_c == "x");
                o_has_result = 1'b1;
                o_result.code_kind = KIND_RAW;
                if (w_none) begin
                    o_result.code_kind      = KIND_UNKNOWN;
                    o_result.returned_chars = 2'd1;
                end else begin
                    case (w_c) inside
                        "a": o_result.code_value = 32'h07;
                        "b": o_result.code_value = 32'h08;
                        "e", "E": o_result.code_value = 32'h1B;
                        "f": o_result.code_value = 32'h0C;
                        "n": o_result.code_value = 32'h0A;
                        "r": o_result.code_value = 32'h0D;
                        "t": o_result.code_value = 32'h09;
                        "v": o_result.code_value = 32'h0B;
                        "\\": o_result.code_value = 32'h5C;
                        "'": begin
                            if (i_c_style) begin
                                o_result.code_value = 32'h27;
                            end else begin
                                o_result.code_kind      = KIND_UNKNOWN;
                                o_result.returned_chars = 2'd1;
                            end
                        end
                        "c": begin
                            if (i_c_style) begin
                                o_state.phase = PH_CTRL;
                                o_has_result  = 1'b0;
                            end else begin
                                o_result.code_kind      = KIND_UNKNOWN;
                                o_result.returned_chars = 2'd1;
                            end
                        end
                        "0": begin
                            o_state.phase = PH_OCT;
                            o_state.limit = OCT_DIGITS;
                            o_state.count = i_c_style ? 4'd1 : 4'd0;
                            o_has_result  = 1'b0;
                        end
                        ["1":"7"]: begin
                            if (i_c_style) begin
                                o_state.phase = PH_OCT;
                                o_state.limit = OCT_DIGITS;
                                o_state.count = 4'd1;
                                o_state.acc   = ACC_BITS'(w_c[2:0]);
                                o_has_result  = 1'b0;
                            end else begin
                                o_result.code_kind      = KIND_UNKNOWN;
                                o_result.returned_chars = 2'd1;
                            end
                        end
                        "x": begin
                            o_state.phase = PH_HEX;
                            o_state.limit = i_c_style ? 4'd0 : HEX_X_LIMIT;
                            o_has_result  = 1'b0;
                        end
                        "u": begin
                            o_state.phase = PH_HEX;
                            o_state.limit = HEX_U_LIMIT;
                            o_has_result  = 1'b0;
                        end
                        "U": begin
                            o_state.phase = PH_HEX;
                            o_state.limit = HEX_W_LIMIT;
                            o_has_result  = 1'b0;
                        end
                        default: begin
                            o_result.code_kind      = KIND_UNKNOWN;
                            o_result.returned_chars = 2'd1;
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import bed_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_MAX    = 10;
    localparam int PHASE_ITEMS   = 150;
    localparam int N_PHASES      = 6;

    localparam logic [1:0] STALL_NONE     = 2'd0;
    localparam logic [1:0] STALL_LIGHT    = 2'd1;
    localparam logic [1:0] STALL_HEAVY    = 2'd2;
    localparam logic [1:0] STALL_PERIODIC = 2'd3;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;

    backslash_escape_decoder DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Escape state of the decoder as the testbench sees it
    logic                c_style_m = 1'b0;
    logic [1:0]          esc_phase = PH_IDLE;
    logic                esc_is_x  = 1'b0;
    logic [3:0]          esc_count = '0;
    logic [3:0]          esc_limit = '0;
    logic [ACC_BITS-1:0] esc_acc   = '0;

    t_in  char_q[$];
    t_out code_q[$];

    int   n_pushed   = 0;
    int   err_cnt    = 0;
    int   cycle_cnt  = 0;
    int   burst_left = 0;
    int   gap_left   = 0;
    bit   idle_on    = 1'b1;
    logic [1:0] stall_mode = STALL_LIGHT;

    logic in_fire_s  = 1'b0;
    logic out_fire_s = 1'b0;
    t_out out_data_s = '0;
    t_out predicted;
    t_out wanted;

    function automatic t_out close_escape(logic [31:0] value, logic [1:0] kind,
                                          logic [1:0] ret);
        t_out r;
        r.code_value     = value;
        r.code_kind      = kind;
        r.returned_chars = ret;
        esc_phase = PH_IDLE;
        esc_count = '0;
        esc_limit = '0;
        esc_acc   = '0;
        return r;
    endfunction

    function automatic t_out close_hex(logic [1:0] ret);
        // no digits at all: hand back the letter as well
        if (esc_count == 0)
            return close_escape(32'd0, KIND_UNKNOWN, ret + 2'd1);
        return close_escape(esc_acc[31:0],
                            ((c_style_m && esc_acc > 'hFF) || !esc_is_x) ? KIND_UCS : KIND_RAW,
                            ret);
    endfunction

    function automatic int hex_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        return -1;
    endfunction

    function automatic bit decode_char(input t_in it, output t_out res);
        logic [7:0] c;
        logic       none;
        int         d;
        logic [7:0] val;
        bit         known;
        c     = it.char_in;
        none  = it.no_more;
        res   = '0;
        val   = '0;
        known = 1'b0;
        case (esc_phase)
            PH_CTRL: begin
                res = close_escape(none ? 32'd0 : (c == "?" ? 32'h7F : {24'd0, c & 8'h9F}),
                                   KIND_RAW, 2'd0);
                return 1'b1;
            end
            PH_OCT: begin
                if (none || c < "0" || c > "7") begin
                    res = close_escape({24'd0, esc_acc[7:0]}, KIND_RAW, 2'd1);
                    return 1'b1;
                end
                esc_acc   = ((esc_acc << 3) + ACC_BITS'(c - "0")) & 'h1FF;
                esc_count = esc_count + 4'd1;
                if (esc_count >= esc_limit) begin
                    res = close_escape({24'd0, esc_acc[7:0]}, KIND_RAW, 2'd0);
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_HEX: begin
                d = none ? -1 : hex_value(c);
                if (d < 0) begin
                    res = close_hex(2'd1);
                    return 1'b1;
                end
                esc_acc = (esc_acc << 4) + ACC_BITS'(d);
                if (esc_count < COUNT_MAX)
                    esc_count = esc_count + 4'd1;
                if (esc_limit != 0 && esc_count >= esc_limit) begin
                    res = close_hex(2'd0);
                    return 1'b1;
                end
                return 1'b0;
            end
            default: ;
        endcase

        // a new escape letter
        esc_is_x  = !none && c == "x";
        esc_acc   = '0;
        esc_count = '0;
        esc_limit = '0;
        esc_phase = PH_IDLE;
        if (none) begin
            res = close_escape(32'd0, KIND_UNKNOWN, 2'd1);
            return 1'b1;
        end
        case (c)
            "a":      begin val = 8'h07; known = 1'b1; end
            "b":      begin val = 8'h08; known = 1'b1; end
            "e", "E": begin val = 8'h1B; known = 1'b1; end
            "f":      begin val = 8'h0C; known = 1'b1; end
            "n":      begin val = 8'h0A; known = 1'b1; end
            "r":      begin val = 8'h0D; known = 1'b1; end
            "t":      begin val = 8'h09; known = 1'b1; end
            "v":      begin val = 8'h0B; known = 1'b1; end
            "\\":     begin val = 8'h5C; known = 1'b1; end
            "'": begin
                val   = 8'h27;
                known = c_style_m;
            end
            "c": begin
                if (c_style_m) begin
                    esc_phase = PH_CTRL;
                    return 1'b0;
                end
            end
            "0", "1", "2", "3", "4", "5", "6", "7": begin
                if (c == "0" || c_style_m) begin
                    esc_phase = PH_OCT;
                    esc_limit = OCT_DIGITS;
                    // in C style the letter is already the first digit
                    if (c_style_m) begin
                        esc_acc   = ACC_BITS'(c - "0");
                        esc_count = 4'd1;
                    end
                    return 1'b0;
                end
            end
            "x": begin
                esc_phase = PH_HEX;
                esc_limit = c_style_m ? 4'd0 : HEX_X_LIMIT;
                return 1'b0;
            end
            "u": begin
                esc_phase = PH_HEX;
                esc_limit = HEX_U_LIMIT;
                return 1'b0;
            end
            "U": begin
                esc_phase = PH_HEX;
                esc_limit = HEX_W_LIMIT;
                return 1'b0;
            end
            default: ;
        endcase
        if (known)
            res = close_escape({24'd0, val}, KIND_RAW, 2'd0);
        else
            res = close_escape(32'd0, KIND_UNKNOWN, 2'd1);
        return 1'b1;
    endfunction

    // Sample both handshakes away from the active edge
    always @(negedge clk) begin
        in_fire_s  = in_valid && !in_stall;
        out_fire_s = out_valid && !out_stall;
        out_data_s = out_data;
    end

    // Sender: random-length bursts, random gaps unless idle_on is clear
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_fire_s) begin
                if (decode_char(in_data, predicted))
                    code_q.push_back(predicted);
                if (burst_left > 0)
                    burst_left--;
            end
            if (!in_valid || in_fire_s) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = (!idle_on || $urandom_range(0, 2) == 0) ? 0
                                                                          : $urandom_range(1, 6);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (char_q.size() != 0) begin
                    in_data  <= char_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((cycle_cnt % 9) < 4);
        endcase
    end

    always @(posedge clk) begin
        if (out_fire_s) begin
            if (code_q.size() == 0) begin
                if (err_cnt < REPORT_MAX)
                    $display("unexpected code: value %h kind %0d returned %0d",
                             out_data_s.code_value, out_data_s.code_kind,
                             out_data_s.returned_chars);
                err_cnt++;
            end else begin
                wanted = code_q.pop_front();
                if (out_data_s.code_value !== wanted.code_value ||
                    out_data_s.code_kind !== wanted.code_kind ||
                    out_data_s.returned_chars !== wanted.returned_chars) begin
                    if (err_cnt < REPORT_MAX)
                        $display("code mismatch: expected value %h kind %0d returned %0d, got value %h kind %0d returned %0d",
                                 wanted.code_value, wanted.code_kind,
                                 wanted.returned_chars, out_data_s.code_value,
                                 out_data_s.code_kind, out_data_s.returned_chars);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_char(input logic [7:0] c);
        t_in it;
        it.char_in = c;
        it.no_more = 1'b0;
        char_q.push_back(it);
        n_pushed++;
    endtask

    task automatic push_none();
        t_in it;
        // the character is ignored here, so let it wander
        it.char_in = 8'($urandom);
        it.no_more = 1'b1;
        char_q.push_back(it);
        n_pushed++;
    endtask

    task automatic end_run();
        case ($urandom_range(0, 3))
            0:       push_none();
            1:       push_char(8'($urandom_range(0, 255)));
            default: ;
        endcase
    endtask

    task automatic gen_escape();
        string      letters;
        int         kind;
        int         n;
        int         d;
        int         i;
        logic [7:0] letter;
        letters = "abeEfnrtv\\'";
        kind    = $urandom_range(0, 9);
        if (kind < 2) begin
            push_char(letters[$urandom_range(0, letters.len() - 1)]);
        end else if (kind < 3) begin
            push_char("c");
            if ($urandom_range(0, 7) == 0)
                push_none();
            else
                push_char(8'($urandom_range(0, 255)));
        end else if (kind < 5) begin
            push_char($urandom_range(0, 1) ? 8'("0") : 8'("0" + $urandom_range(1, 7)));
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++)
                push_char(8'("0" + $urandom_range(0, 7)));
            end_run();
        end else if (kind < 9) begin
            case ($urandom_range(0, 2))
                0: begin
                    letter = "x";
                    // now and then a long run to wrap the accumulator
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 18)
                                                    : $urandom_range(0, 3);
                end
                1: begin
                    letter = "u";
                    n      = $urandom_range(0, 5);
                end
                default: begin
                    letter = "U";
                    n      = $urandom_range(0, 9);
                end
            endcase
            push_char(letter);
            for (i = 0; i < n; i++) begin
                d = $urandom_range(0, 15);
                if (d < 10)
                    push_char(8'("0" + d));
                else
                    push_char(8'(($urandom_range(0, 1) ? "a" : "A") + d - 10));
            end
            end_run();
        end else begin
            if ($urandom_range(0, 3) == 0)
                push_none();
            else
                push_char(8'($urandom_range(0, 255)));
        end
    endtask

    // Wait until every transfer is out, then let the pipeline settle
    task automatic drain();
        do
            @(negedge clk);
        while (char_q.size() != 0 || in_valid || code_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_style(input logic v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        c_style_m = v;
    endtask

    initial begin
        int p;
        int start;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // plain style straight out of reset
        push_char("n");
        push_char("'");
        push_char(8'h00);
        push_char("0");
        push_char("7");
        push_char("7");
        push_char("7");
        push_char("x");
        push_char("F");
        push_char("f");
        push_char("x");
        push_none();
        push_none();
        drain();

        write_style(1'b1);
        push_char("'");
        push_char("c");
        push_char("?");
        push_char("c");
        push_char(8'hFF);
        push_char("c");
        push_none();
        push_char("4");
        push_char("z");
        push_char("x");
        push_char("1");
        push_char("2");
        push_char("3");
        push_char("g");
        drain();

        for (p = 0; p < N_PHASES; p++) begin
            write_style(p[0]);
            stall_mode = 2'(p % 4);
            idle_on    = (p != 2);
            start      = n_pushed;
            while (n_pushed - start < PHASE_ITEMS)
                gen_escape();
            // aim to leave an escape open over the next register write
            case ($urandom_range(0, 3))
                0:       push_char("x");
                1:       push_char("c");
                2:       push_char("0");
                default: push_char("1");
            endcase
            drain();
        end

        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (err_cnt == 0 && code_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
src/bed_pkg.sv
src/bed_step.sv
src/backslash_escape_decoder.sv
test/tb_top.sv
